// ----- src/segment_feed_rate_limiter_assert.svh -----
// assertion macros for the segment feed rate limiter checker
// used by sfrl_checker.sv, which expects i_clk and i_rst_n in scope
`ifndef SEGMENT_FEED_RATE_LIMITER_ASSERT_SVH
`define SEGMENT_FEED_RATE_LIMITER_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define SFRL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfrl check failed");

// next-cycle implication, also checked through reset
`define SFRL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("sfrl check failed");

`endif

// ----- src/sfrl_pkg.sv -----
// shared widths, types and register codes for the segment feed rate limiter
// no dependencies
`timescale 1ns / 1ps

package sfrl_pkg;

    localparam int NUM_AXES   = 4;
    localparam int POS_W      = 22;
    localparam int FEED_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int D_W        = 22;
    localparam int SQ_W       = 2 * D_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int FRAC_W     = 8;
    localparam int X_W        = SUM_W + 2 * FRAC_W;
    localparam int SQ_STAGES  = X_W / 2;
    localparam int ROOT_W     = SQ_STAGES;
    localparam int REM_W      = ROOT_W + 2;
    localparam int PROD_W     = FEED_W + ROOT_W;
    localparam int NUM_W      = PROD_W - FRAC_W;
    localparam int Q_W        = FEED_W + 1;
    localparam int DIV_STAGES = Q_W;
    localparam int DIV_LAT    = DIV_STAGES + 1;
    localparam int NUM_DIV    = NUM_AXES + 1;
    localparam int LATENCY    = 3 + SQ_STAGES + 1 + DIV_LAT + 2;

    localparam logic [FEED_W-1:0] CUT_FEED_RST = FEED_W'(1000);
    localparam logic [FEED_W-1:0] MAX_FEED_RST = FEED_W'(10000);
    localparam logic [FEED_W-1:0] MIN_FEED_RST = FEED_W'(10);
    localparam logic [Q_W-1:0]    Q_SAT        = Q_W'(1) << FEED_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CUT_FEED = 3'd0,
        REG_MAX_FEED = 3'd1,
        REG_MIN_FEED = 3'd2,
        REG_RATE_X   = 3'd3,
        REG_RATE_Y   = 3'd4,
        REG_RATE_Z   = 3'd5,
        REG_RATE_A   = 3'd6
    } t_cfg_reg;

    typedef logic [D_W-1:0] t_delta;

    typedef struct packed {
        t_delta [NUM_AXES-1:0] d;
        logic [POS_W-1:0]      slen;
    } t_side;

    typedef struct packed {
        logic                mz;
        logic                sz;
        logic [NUM_AXES-1:0] use_cap;
    } t_flags;

endpackage

// ----- src/sfrl_sqrt.sv -----
// pipelined integer square root, one result bit per stage
// computes floor(sqrt(sum * 2^16)) and carries side data along; uses sfrl_pkg
`timescale 1ns / 1ps

module sfrl_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [sfrl_pkg::SUM_W-1:0]  i_sum,
    input  sfrl_pkg::t_side             i_side,
    output logic                        o_vld,
    output logic [sfrl_pkg::ROOT_W-1:0] o_root,
    output sfrl_pkg::t_side             o_side
);
    import sfrl_pkg::*;

    logic [REM_W-1:0]  r_rem  [SQ_STAGES];
    logic [ROOT_W-1:0] r_root [SQ_STAGES];
    logic [X_W-1:0]    r_x    [SQ_STAGES];
    t_side             r_side [SQ_STAGES];
    logic              r_vld  [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [REM_W-1:0]  w_rem_prev;
        logic [ROOT_W-1:0] w_root_prev;
        logic [X_W-1:0]    w_x_prev;
        t_side             w_side_prev;
        logic              w_vld_prev;
        logic [REM_W+1:0]  w_trial;
        logic [REM_W+1:0]  w_t;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_rem_prev  = '0;
            assign w_root_prev = '0;
            assign w_x_prev    = {i_sum, {(2 * FRAC_W){1'b0}}};
            assign w_side_prev = i_side;
            assign w_vld_prev  = i_vld;
        end else begin : g_next
            assign w_rem_prev  = r_rem[k-1];
            assign w_root_prev = r_root[k-1];
            assign w_x_prev    = r_x[k-1];
            assign w_side_prev = r_side[k-1];
            assign w_vld_prev  = r_vld[k-1];
        end

        // bring down the next bit pair, try subtracting 4*root + 1
        assign w_trial = {w_rem_prev, w_x_prev[2*(SQ_STAGES-1-k)+1 -: 2]};
        assign w_t     = {1'b0, w_root_prev, 2'b01};
        assign w_ge    = (w_trial >= w_t);

        always_ff @(posedge i_clk) begin
            if (w_ge) begin
                r_rem[k] <= REM_W'(w_trial - w_t);
            end else begin
                r_rem[k] <= REM_W'(w_trial);
            end
            r_root[k] <= {w_root_prev[ROOT_W-2:0], w_ge};
            r_x[k]    <= w_x_prev;
            r_side[k] <= w_side_prev;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld_prev;
            end
        end
    end

    assign o_vld  = r_vld[SQ_STAGES-1];
    assign o_root = r_root[SQ_STAGES-1];
    assign o_side = r_side[SQ_STAGES-1];

endmodule

// ----- src/sfrl_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// quotient saturates at 2^17 when it would not fit; uses sfrl_pkg
`timescale 1ns / 1ps

module sfrl_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [sfrl_pkg::NUM_W-1:0] i_num,
    input  logic [sfrl_pkg::D_W-1:0]   i_den,
    output logic                       o_vld,
    output logic [sfrl_pkg::Q_W-1:0]   o_q
);
    import sfrl_pkg::*;

    // setup stage: overflow check on the high part
    logic [D_W-1:0] r_rem0;
    logic [Q_W-1:0] r_low0;
    logic [D_W-1:0] r_den0;
    logic           r_ovf0;
    logic           r_vld0;

    logic [D_W-1:0] r_rem [DIV_STAGES];
    logic [Q_W-1:0] r_low [DIV_STAGES];
    logic [Q_W-1:0] r_q   [DIV_STAGES];
    logic [D_W-1:0] r_den [DIV_STAGES];
    logic           r_ovf [DIV_STAGES];
    logic           r_vld [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        r_rem0 <= i_num[NUM_W-1:Q_W];
        r_low0 <= i_num[Q_W-1:0];
        r_den0 <= i_den;
        r_ovf0 <= (i_num[NUM_W-1:Q_W] >= i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= i_vld;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [D_W-1:0] w_rem_prev;
        logic [Q_W-1:0] w_low_prev;
        logic [Q_W-1:0] w_q_prev;
        logic [D_W-1:0] w_den_prev;
        logic           w_ovf_prev;
        logic           w_vld_prev;
        logic [D_W:0]   w_trial;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign w_rem_prev = r_rem0;
            assign w_low_prev = r_low0;
            assign w_q_prev   = '0;
            assign w_den_prev = r_den0;
            assign w_ovf_prev = r_ovf0;
            assign w_vld_prev = r_vld0;
        end else begin : g_next
            assign w_rem_prev = r_rem[k-1];
            assign w_low_prev = r_low[k-1];
            assign w_q_prev   = r_q[k-1];
            assign w_den_prev = r_den[k-1];
            assign w_ovf_prev = r_ovf[k-1];
            assign w_vld_prev = r_vld[k-1];
        end

        assign w_trial = {w_rem_prev, w_low_prev[Q_W-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den_prev});

        always_ff @(posedge i_clk) begin
            if (w_ge) begin
                r_rem[k] <= D_W'(w_trial - {1'b0, w_den_prev});
            end else begin
                r_rem[k] <= D_W'(w_trial);
            end
            r_low[k] <= {w_low_prev[Q_W-2:0], 1'b0};
            r_q[k]   <= {w_q_prev[Q_W-2:0], w_ge};
            r_den[k] <= w_den_prev;
            r_ovf[k] <= w_ovf_prev;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld_prev;
            end
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_q   = r_ovf[DIV_STAGES-1] ? Q_SAT : r_q[DIV_STAGES-1];

endmodule

// ----- src/segment_feed_rate_limiter.sv -----
// top level of the segment feed rate limiter: config registers, deltas, squares,
// products and final min/clamp; depends on sfrl_pkg, sfrl_sqrt and sfrl_div
//
//  channel   handshake                     payload
//  segment   start / busy                  i_start_*, i_end_*, i_surface_length
//  feed      o_valid (strobe, no stall)    o_feed
//  config    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// one segment per cycle; each result is registered through the deltas, squares, sum,
// 31-stage square root, products, 19-stage dividers, minimum and clamp, which set the latency
// busy and o_cfg_ready are held off only while reset is applied and until the clock samples it released
// synchronous active-low reset clears all valid bits; in-flight items are dropped
`timescale 1ns / 1ps

module segment_feed_rate_limiter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sfrl_pkg::POS_W-1:0]   i_start_x,
    input  logic signed [sfrl_pkg::POS_W-1:0]   i_start_y,
    input  logic signed [sfrl_pkg::POS_W-1:0]   i_start_z,
    input  logic signed [sfrl_pkg::POS_W-1:0]   i_start_a,
    input  logic signed [sfrl_pkg::POS_W-1:0]   i_end_x,
    input  logic signed [sfrl_pkg::POS_W-1:0]   i_end_y,
    input  logic signed [sfrl_pkg::POS_W-1:0]   i_end_z,
    input  logic signed [sfrl_pkg::POS_W-1:0]   i_end_a,
    input  logic [sfrl_pkg::POS_W-1:0]          i_surface_length,
    output logic                                o_valid,
    output logic [sfrl_pkg::FEED_W-1:0]         o_feed,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sfrl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sfrl_pkg::FEED_W-1:0]         i_cfg_data
);
    import sfrl_pkg::*;

    logic              r_busy;
    logic [FEED_W-1:0] r_cut;
    logic [FEED_W-1:0] r_max;
    logic [FEED_W-1:0] r_min;
    logic [FEED_W-1:0] r_rate [NUM_AXES];

    logic signed [POS_W-1:0] w_start [NUM_AXES];
    logic signed [POS_W-1:0] w_end   [NUM_AXES];
    logic signed [POS_W:0]   w_diff  [NUM_AXES];
    t_side                   w_side_in;
    logic                    w_acc;

    logic              r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_side             r_side1, r_side2, r_side3;
    logic [SQ_W-1:0]   r_sq [NUM_AXES];
    logic [SUM_W-1:0]  r_sum;

    logic              w_sq_vld;
    logic [ROOT_W-1:0] w_mlen;
    t_side             w_sq_side;

    logic [PROD_W-1:0] r_prod [NUM_DIV];
    logic [D_W-1:0]    r_den  [NUM_DIV];
    t_flags            r_fl4;
    t_flags            r_fl [DIV_LAT];

    logic [NUM_DIV-1:0] w_div_vld;
    logic [Q_W-1:0]     w_q [NUM_DIV];

    logic [Q_W-1:0]    w_f;
    logic [Q_W-1:0]    r_f5;
    logic              r_mz5;
    logic [FEED_W-1:0] w_c;
    logic [FEED_W-1:0] r_feed;

    assign busy        = r_busy;
    assign o_cfg_ready = ~r_busy;
    assign w_acc       = start & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut <= CUT_FEED_RST;
            r_max <= MAX_FEED_RST;
            r_min <= MIN_FEED_RST;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_rate[a] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_CUT_FEED: r_cut     <= i_cfg_data;
                REG_MAX_FEED: r_max     <= i_cfg_data;
                REG_MIN_FEED: r_min     <= i_cfg_data;
                REG_RATE_X:   r_rate[0] <= i_cfg_data;
                REG_RATE_Y:   r_rate[1] <= i_cfg_data;
                REG_RATE_Z:   r_rate[2] <= i_cfg_data;
                REG_RATE_A:   r_rate[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: absolute axis deltas
    assign w_start[0] = i_start_x;
    assign w_start[1] = i_start_y;
    assign w_start[2] = i_start_z;
    assign w_start[3] = i_start_a;
    assign w_end[0]   = i_end_x;
    assign w_end[1]   = i_end_y;
    assign w_end[2]   = i_end_z;
    assign w_end[3]   = i_end_a;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_diff[a] = (POS_W+1)'(w_end[a]) - (POS_W+1)'(w_start[a]);
            if (w_diff[a][POS_W]) begin
                w_side_in.d[a] = D_W'(-w_diff[a]);
            end else begin
                w_side_in.d[a] = D_W'(w_diff[a]);
            end
        end
        w_side_in.slen = i_surface_length;
    end

    always_ff @(posedge i_clk) begin
        r_side1 <= w_side_in;
        for (int a = 0; a < NUM_AXES; a++) begin
            r_sq[a] <= SQ_W'(r_side1.d[a]) * SQ_W'(r_side1.d[a]);
        end
        r_side2 <= r_side1;
        r_sum   <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]) + SUM_W'(r_sq[3]);
        r_side3 <= r_side2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= w_sq_vld;
            r_v5 <= &w_div_vld;
            r_v6 <= r_v5;
        end
    end

    sfrl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v3),
        .i_sum   (r_sum),
        .i_side  (r_side3),
        .o_vld   (w_sq_vld),
        .o_root  (w_mlen),
        .o_side  (w_sq_side)
    );

    // stage 4: numerators and divisors for the base feed and each axis cap
    always_ff @(posedge i_clk) begin
        r_prod[0] <= PROD_W'(r_cut) * PROD_W'(w_mlen);
        r_den[0]  <= w_sq_side.slen;
        for (int a = 0; a < NUM_AXES; a++) begin
            r_prod[a+1]      <= PROD_W'(r_rate[a]) * PROD_W'(w_mlen);
            r_den[a+1]       <= w_sq_side.d[a];
            r_fl4.use_cap[a] <= (w_sq_side.d[a] != '0) && (r_rate[a] != '0);
        end
        r_fl4.mz <= (w_mlen == '0);
        r_fl4.sz <= (w_sq_side.slen == '0);
    end

    for (genvar j = 0; j < NUM_DIV; j++) begin : g_div
        sfrl_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (r_v4),
            .i_num   (r_prod[j][PROD_W-1:FRAC_W]),
            .i_den   (r_den[j]),
            .o_vld   (w_div_vld[j]),
            .o_q     (w_q[j])
        );
    end

    // flags ride alongside the dividers
    always_ff @(posedge i_clk) begin
        r_fl[0] <= r_fl4;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_fl[k] <= r_fl[k-1];
        end
    end

    // stage 5: smallest of base feed (max feed when surface length is zero) and active axis caps
    always_comb begin
        if (r_fl[DIV_LAT-1].sz) begin
            w_f = {1'b0, r_max};
        end else begin
            w_f = w_q[0];
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            if (r_fl[DIV_LAT-1].use_cap[a] && (w_q[a+1] < w_f)) begin
                w_f = w_q[a+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_f5  <= w_f;
        r_mz5 <= r_fl[DIV_LAT-1].mz;
    end

    // stage 6: upper clamp, then lower clamp; zero-length move passes cut feed
    always_comb begin
        if (r_f5 > {1'b0, r_max}) begin
            w_c = r_max;
        end else begin
            w_c = r_f5[FEED_W-1:0];
        end
        if (w_c < r_min) begin
            w_c = r_min;
        end
        if (r_mz5) begin
            w_c = r_cut;
        end
    end

    always_ff @(posedge i_clk) begin
        r_feed <= w_c;
    end

    assign o_valid = r_v6;
    assign o_feed  = r_feed;

endmodule

// ----- src/sfrl_checker.sv -----
// port-level checks for the segment feed rate limiter, bound to the top level
// depends on sfrl_pkg and segment_feed_rate_limiter_assert.svh
`timescale 1ns / 1ps

module sfrl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [sfrl_pkg::FEED_W-1:0] o_feed,
    input logic                        o_cfg_ready
);
    import sfrl_pkg::*;

`include "segment_feed_rate_limiter_assert.svh"

    // every result strobe traces back to a segment transfer a fixed time earlier
    `SFRL_ASSERT_IMP(a_out_has_in, o_valid, $past(start && !busy, LATENCY))

    // both channels are open in the cycle after reset is released
    `SFRL_ASSERT_IMP(a_open_after_rst, $past(i_rst_n), !busy && o_cfg_ready)

    // reset flushes the pipe and closes the channels
    `SFRL_ASSERT_NXT(a_rst_flush, !i_rst_n, !o_valid && busy && !o_cfg_ready)

    // a delivered feed is never unknown
    `SFRL_ASSERT_IMP(a_feed_known, o_valid, !$isunknown(o_feed))

endmodule

bind segment_feed_rate_limiter sfrl_checker u_sfrl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_feed      (o_feed),
    .o_cfg_ready (o_cfg_ready)
);
